/* src/fuzzy_incremental_pid_unit_defines.svh */
// Assertion macros shared by the modules of the controller.
`ifndef FUZZY_INCREMENTAL_PID_UNIT_DEFINES_SVH
`define FUZZY_INCREMENTAL_PID_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fip assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fip assertion failed");

`endif

/* src/fip_pkg.sv */
package fip_pkg;

    localparam int KW = 24;
    localparam int BW = 27;

    localparam logic [2:0] CFG_GAIN_P   = 3'd0;
    localparam logic [2:0] CFG_GAIN_I   = 3'd1;
    localparam logic [2:0] CFG_GAIN_D   = 3'd2;
    localparam logic [2:0] CFG_MARGIN   = 3'd3;
    localparam logic [2:0] CFG_SEP_OFFS = 3'd4;

    typedef logic signed [2:0] t_rom [0:6][0:6];

    localparam t_rom ROM_P = '{
        '{ 3,  3,  2,  2,  1,  1,  0},
        '{ 3,  3,  2,  2,  1,  0,  0},
        '{ 2,  2,  2,  1,  0, -1, -2},
        '{ 2,  1,  1,  0, -1, -2, -2},
        '{ 1,  1,  0, -1, -1, -2, -2},
        '{ 0,  0, -1, -2, -2, -2, -3},
        '{ 0, -1, -1, -2, -2, -3, -3}
    };

    localparam t_rom ROM_I = '{
        '{-3, -3, -3, -2, -2,  0,  0},
        '{-3, -3, -2, -2, -1,  0,  0},
        '{-2, -2, -1, -1,  0,  1,  1},
        '{-2, -1, -1,  0,  1,  1,  2},
        '{-1, -1,  0,  1,  1,  2,  2},
        '{ 0,  0,  1,  2,  2,  3,  3},
        '{ 0,  0,  1,  2,  3,  3,  3}
    };

    localparam t_rom ROM_D = '{
        '{ 1,  1,  0,  0,  0,  3,  3},
        '{-1, -1, -1, -1,  0, -1,  2},
        '{-3, -3, -2, -1,  0,  1,  2},
        '{-3, -2, -2, -1,  0,  1,  2},
        '{-3, -2, -1, -1,  0,  1,  1},
        '{-2, -1, -1, -1,  0,  1,  1},
        '{ 1,  0,  0,  0,  0,  3,  3}
    };

    typedef struct packed {
        logic       load;
        logic       fuzz;
        logic       wmul;
        logic       blend;
        logic       mac;
        logic       finish;
        logic [1:0] step;
    } t_cmd;

    typedef struct packed {
        logic use_i;
    } t_status;

endpackage

/* src/fuzzy_incremental_pid_unit.sv */
// Channel   Valid     Stall     Payload
// request   i_valid   o_stall   i_target_speed, i_measured_speed
// result    o_valid   i_stall   o_drive_value, o_integral_applied
// A request passes to its result through one fuzzify step, four weight products,
// three gain blends through the rule tables, two or three multiply-accumulate steps
// (three when the integral term is used) and a saturating update; the products share one
// multiplier. Reset is synchronous and active low; it clears the history, the accumulator
// and the config registers to their defaults. A result waits in the output register while
// i_stall is high; the next request is accepted meanwhile and its own result waits.
module fuzzy_incremental_pid_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [22:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_target_speed,
    input  logic signed [23:0] i_measured_speed,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_drive_value,
    output logic               o_integral_applied
);
    import fip_pkg::*;

    t_cmd    cmd;
    t_status status;

    fip_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    fip_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_target_speed     (i_target_speed),
        .i_measured_speed   (i_measured_speed),
        .o_drive_value      (o_drive_value),
        .o_integral_applied (o_integral_applied)
    );
endmodule

/* src/fip_ctrl.sv */
`include "fuzzy_incremental_pid_unit_defines.svh"
module fip_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  fip_pkg::t_status i_status,
    output fip_pkg::t_cmd    o_cmd
);
    import fip_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FUZZ  = 6'b000010,
        S_WMUL  = 6'b000100,
        S_BLEND = 6'b001000,
        S_MAC   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_valid, n_valid;
    logic       accept, slot_free;

    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_valid || !i_stall;
    assign o_valid   = r_valid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_valid = r_valid;
        o_cmd   = '0;
        o_cmd.step = r_step;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state = S_FUZZ;
                end
            end
            S_FUZZ: begin
                o_cmd.fuzz = 1'b1;
                n_step  = 2'd0;
                n_state = S_WMUL;
            end
            S_WMUL: begin
                o_cmd.wmul = 1'b1;
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_step  = 2'd0;
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                o_cmd.blend = 1'b1;
                n_step = r_step + 2'd1;
                if (r_step == 2'd2) begin
                    n_step  = 2'd0;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                n_step = r_step + 2'd1;
                if (r_step == 2'd2 || (r_step == 2'd1 && !i_status.use_i)) begin
                    n_step  = 2'd0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    `FIP_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_state == S_FUZZ)
    `FIP_ASSERT_NOW(a_mac_step_range, i_clk, i_rst_n, r_state == S_MAC, r_step != 2'd3)
    `FIP_ASSERT_NEXT(a_finish_shows, i_clk, i_rst_n, o_cmd.finish, r_valid)
    `FIP_ASSERT_NOW(a_blend_step_range, i_clk, i_rst_n, r_state == S_BLEND, r_step != 2'd3)
endmodule

/* src/fip_datapath.sv */
module fip_datapath #(
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fip_pkg::t_cmd       i_cmd,
    output fip_pkg::t_status    o_status,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [22:0]         i_cfg_data,
    input  logic signed [23:0]  i_target_speed,
    input  logic signed [23:0]  i_measured_speed,
    output logic signed [31:0]  o_drive_value,
    output logic                o_integral_applied
);
    import fip_pkg::*;

    localparam int WW  = FRAC_BITS + 1;
    localparam int WP  = 2 * FRAC_BITS + 1;
    localparam int BSW = WP + 6;
    localparam int PW  = KW + BW;
    localparam int AW  = PW + 3;
    localparam logic signed [25:0] RANGE = 26'(3 << FRAC_BITS);
    localparam logic signed [AW:0] MAX32 = (AW+1)'(64'sd2147483647);
    localparam logic signed [AW:0] MIN32 = -(AW+1)'(64'sd2147483648);

    typedef struct packed {
        logic [2:0]    idx;
        logic [WW-1:0] wl;
        logic [WW-1:0] wr;
    } t_fz;

    function automatic t_fz fuzzify(input logic signed [25:0] x);
        t_fz                f;
        logic signed [25:0] u;
        logic [2:0]         i;
        f = '0;
        if (x <= RANGE && x >= -RANGE) begin
            u = x + RANGE;
            i = 3'(u >>> FRAC_BITS);
            if (i > 3'd5) begin
                i = 3'd5;
            end
            f.idx = i;
            f.wl  = WW'(((26'(i) + 26'd1) << FRAC_BITS) - u);
            f.wr  = WW'(u - (26'(i) << FRAC_BITS));
        end
        return f;
    endfunction

    logic signed [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic [22:0]        r_margin, r_sep;
    logic signed [23:0] r_target, r_meas;
    logic signed [24:0] r_e, r_ep, r_ep2, r_ei;
    logic signed [31:0] r_accum;
    logic               r_use_i, r_applied;
    logic [2:0]         r_ie, r_ic;
    logic [WW-1:0]      r_el, r_er, r_cl, r_cr;
    logic [WP-1:0]      r_w [0:3];
    logic signed [KW-1:0] r_kp, r_ki, r_kd;
    logic signed [AW-1:0] r_acc;

    logic signed [25:0] ec, meas26, hi, lo;
    logic signed [24:0] sep_diff, ei;
    logic [24:0]        abs_e, abs_sep;
    t_fz                fz_e, fz_c;
    logic signed [KW-1:0] op_a;
    logic signed [BW-1:0] op_b, d1, d2;
    logic signed [PW-1:0] prod;
    logic signed [BSW-1:0] bsum, bsh;
    logic signed [15:0]   gain_sel;
    logic signed [KW-1:0] k_new;
    logic signed [AW-1:0] inc;
    logic signed [AW:0]   total;
    logic signed [31:0]   sat;

    always_comb begin
        ec     = 26'(r_e) - 26'(r_ep);
        fz_e   = fuzzify(26'(r_e));
        fz_c   = fuzzify(ec);
        meas26 = 26'(r_meas);
        hi     = 26'(r_target) + $signed({3'b000, r_margin});
        lo     = 26'(r_target) - $signed({3'b000, r_margin});
        if (meas26 > hi) begin
            ei = (r_e <= 0) ? r_e : '0;
        end else if (meas26 < lo) begin
            ei = (r_e >= 0) ? r_e : '0;
        end else begin
            ei = r_e;
        end
        sep_diff = 25'(r_target) - $signed({2'b00, r_sep});
        abs_e    = r_e[24] ? 25'(-r_e) : 25'(r_e);
        abs_sep  = sep_diff[24] ? 25'(-sep_diff) : 25'(sep_diff);
    end

    assign d1 = BW'(r_e) - BW'(r_ep);
    assign d2 = BW'(r_e) - (BW'(r_ep) <<< 1) + BW'(r_ep2);

    always_comb begin
        op_a = '0;
        op_b = '0;
        if (i_cmd.wmul) begin
            case (i_cmd.step)
                2'd0:    begin op_a = KW'(r_el); op_b = BW'(r_cl); end
                2'd1:    begin op_a = KW'(r_el); op_b = BW'(r_cr); end
                2'd2:    begin op_a = KW'(r_er); op_b = BW'(r_cl); end
                default: begin op_a = KW'(r_er); op_b = BW'(r_cr); end
            endcase
        end else begin
            case (i_cmd.step)
                2'd0:    begin op_a = r_kp; op_b = d1; end
                2'd1:    begin op_a = r_kd; op_b = d2; end
                default: begin op_a = r_ki; op_b = BW'(r_ei); end
            endcase
        end
        prod = PW'(op_a) * PW'(op_b);
    end

    always_comb begin
        case (i_cmd.step)
            2'd0: begin
                gain_sel = r_gain_p;
                bsum = $signed({1'b0, r_w[0]}) * ROM_P[r_ie][r_ic]
                     + $signed({1'b0, r_w[1]}) * ROM_P[r_ie][r_ic + 3'd1]
                     + $signed({1'b0, r_w[2]}) * ROM_P[r_ie + 3'd1][r_ic]
                     + $signed({1'b0, r_w[3]}) * ROM_P[r_ie + 3'd1][r_ic + 3'd1];
            end
            2'd1: begin
                gain_sel = r_gain_i;
                bsum = $signed({1'b0, r_w[0]}) * ROM_I[r_ie][r_ic]
                     + $signed({1'b0, r_w[1]}) * ROM_I[r_ie][r_ic + 3'd1]
                     + $signed({1'b0, r_w[2]}) * ROM_I[r_ie + 3'd1][r_ic]
                     + $signed({1'b0, r_w[3]}) * ROM_I[r_ie + 3'd1][r_ic + 3'd1];
            end
            default: begin
                gain_sel = r_gain_d;
                bsum = $signed({1'b0, r_w[0]}) * ROM_D[r_ie][r_ic]
                     + $signed({1'b0, r_w[1]}) * ROM_D[r_ie][r_ic + 3'd1]
                     + $signed({1'b0, r_w[2]}) * ROM_D[r_ie + 3'd1][r_ic]
                     + $signed({1'b0, r_w[3]}) * ROM_D[r_ie + 3'd1][r_ic + 3'd1];
            end
        endcase
        bsh   = bsum >>> FRAC_BITS;
        k_new = KW'(gain_sel) + KW'(bsh);
    end

    always_comb begin
        inc   = r_acc >>> FRAC_BITS;
        total = (AW+1)'(r_accum) + (AW+1)'(inc);
        if (total > MAX32) begin
            sat = 32'sh7fffffff;
        end else if (total < MIN32) begin
            sat = 32'sh80000000;
        end else begin
            sat = 32'(total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_margin <= 23'd1280;
            r_sep    <= 23'd5120;
            r_ep     <= '0;
            r_ep2    <= '0;
            r_accum  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GAIN_P:   r_gain_p <= i_cfg_data[15:0];
                    CFG_GAIN_I:   r_gain_i <= i_cfg_data[15:0];
                    CFG_GAIN_D:   r_gain_d <= i_cfg_data[15:0];
                    CFG_MARGIN:   r_margin <= i_cfg_data;
                    CFG_SEP_OFFS: r_sep    <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_cmd.finish) begin
                r_ep2   <= r_ep;
                r_ep    <= r_e;
                r_accum <= sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_target_speed;
            r_meas   <= i_measured_speed;
            r_e      <= 25'(i_target_speed) - 25'(i_measured_speed);
        end
        if (i_cmd.fuzz) begin
            r_ie    <= fz_e.idx;
            r_el    <= fz_e.wl;
            r_er    <= fz_e.wr;
            r_ic    <= fz_c.idx;
            r_cl    <= fz_c.wl;
            r_cr    <= fz_c.wr;
            r_ei    <= ei;
            r_use_i <= (abs_e <= abs_sep);
        end
        if (i_cmd.wmul) begin
            r_w[i_cmd.step] <= WP'(prod);
        end
        if (i_cmd.blend) begin
            case (i_cmd.step)
                2'd0:    r_kp <= k_new;
                2'd1:    r_ki <= k_new;
                default: r_kd <= k_new;
            endcase
        end
        if (i_cmd.mac) begin
            if (i_cmd.step == 2'd0) begin
                r_acc <= AW'(prod);
            end else begin
                r_acc <= r_acc + AW'(prod);
            end
        end
        if (i_cmd.finish) begin
            r_applied <= r_use_i;
        end
    end

    assign o_status.use_i     = r_use_i;
    assign o_drive_value      = r_accum;
    assign o_integral_applied = r_applied;
endmodule

/* test/fuzzy_incremental_pid_unit_test.sv */
module fuzzy_incremental_pid_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fip_pkg::*;

    localparam int FRAC = 8;
    localparam int NUM_REGS = 5;
    localparam int TERM_P = 0;
    localparam int TERM_I = 1;
    localparam int TERM_D = 2;
    localparam int ITEMS_PER_PHASE = 360;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT = 3000;

    localparam byte RULES [3][7][7] = '{
        '{
            '{ 3,  3,  2,  2,  1,  1,  0},
            '{ 3,  3,  2,  2,  1,  0,  0},
            '{ 2,  2,  2,  1,  0, -1, -2},
            '{ 2,  1,  1,  0, -1, -2, -2},
            '{ 1,  1,  0, -1, -1, -2, -2},
            '{ 0,  0, -1, -2, -2, -2, -3},
            '{ 0, -1, -1, -2, -2, -3, -3}
        },
        '{
            '{-3, -3, -3, -2, -2,  0,  0},
            '{-3, -3, -2, -2, -1,  0,  0},
            '{-2, -2, -1, -1,  0,  1,  1},
            '{-2, -1, -1,  0,  1,  1,  2},
            '{-1, -1,  0,  1,  1,  2,  2},
            '{ 0,  0,  1,  2,  2,  3,  3},
            '{ 0,  0,  1,  2,  3,  3,  3}
        },
        '{
            '{ 1,  1,  0,  0,  0,  3,  3},
            '{-1, -1, -1, -1,  0, -1,  2},
            '{-3, -3, -2, -1,  0,  1,  2},
            '{-3, -2, -2, -1,  0,  1,  2},
            '{-3, -2, -1, -1,  0,  1,  1},
            '{-2, -1, -1, -1,  0,  1,  1},
            '{ 1,  0,  0,  0,  0,  3,  3}
        }
    };

    typedef struct {
        logic signed [31:0] drive;
        logic               integ;
    } t_drive_result;

    class t_pid_scoreboard;
        shortint gain_p, gain_i, gain_d;
        longint  margin, sep_offset;
        longint  err_last, err_last2, accum;
        t_drive_result pending_q[$];
        int      errors;

        function new();
            gain_p = 0;
            gain_i = 0;
            gain_d = 0;
            margin = 1280;
            sep_offset = 5120;
            err_last = 0;
            err_last2 = 0;
            accum = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [22:0] data);
            case (addr)
                CFG_GAIN_P:   gain_p = shortint'(data[15:0]);
                CFG_GAIN_I:   gain_i = shortint'(data[15:0]);
                CFG_GAIN_D:   gain_d = shortint'(data[15:0]);
                CFG_MARGIN:   margin = longint'(data);
                CFG_SEP_OFFS: sep_offset = longint'(data);
                default: ;
            endcase
        endfunction

        function void fuzz(longint x, output int idx, output longint wl, output longint wr);
            longint span;
            longint u;
            span = longint'(3) <<< FRAC;
            if (x > span || x < -span) begin
                idx = 0;
                wl = 0;
                wr = 0;
            end else begin
                u = x + span;
                idx = int'(u >>> FRAC);
                if (idx > 5) begin
                    idx = 5;
                end
                wl = (longint'(idx + 1) <<< FRAC) - u;
                wr = u - (longint'(idx) <<< FRAC);
            end
        endfunction

        function longint gain_offset(int term, int ie, longint el, longint er,
                                     int ic, longint cl, longint cr);
            longint s;
            s = el * cl * RULES[term][ie][ic] + el * cr * RULES[term][ie][ic + 1]
              + er * cl * RULES[term][ie + 1][ic] + er * cr * RULES[term][ie + 1][ic + 1];
            return s >>> FRAC;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void note_request(logic signed [23:0] target, logic signed [23:0] meas);
            longint t, m, e, ec, kp, ki, kd, ei, sum, acc;
            longint el, er, cl, cr;
            int ie, ic;
            t_drive_result r;
            t = target;
            m = meas;
            e = t - m;
            ec = e - err_last;
            fuzz(e, ie, el, er);
            fuzz(ec, ic, cl, cr);
            kp = longint'(gain_p) + gain_offset(TERM_P, ie, el, er, ic, cl, cr);
            ki = longint'(gain_i) + gain_offset(TERM_I, ie, el, er, ic, cl, cr);
            kd = longint'(gain_d) + gain_offset(TERM_D, ie, el, er, ic, cl, cr);
            if (m > t + margin) begin
                ei = (e <= 0) ? e : 0;
            end else if (m < t - margin) begin
                ei = (e >= 0) ? e : 0;
            end else begin
                ei = e;
            end
            r.integ = mag(e) <= mag(t - sep_offset);
            sum = kp * (e - err_last) + kd * (e - 2 * err_last + err_last2);
            if (r.integ) begin
                sum += ki * ei;
            end
            acc = accum + (sum >>> FRAC);
            if (acc > 64'sd2147483647) begin
                acc = 64'sd2147483647;
            end
            if (acc < -64'sd2147483648) begin
                acc = -64'sd2147483648;
            end
            accum = acc;
            err_last2 = err_last;
            err_last = e;
            r.drive = acc[31:0];
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] drive, logic integ);
            t_drive_result r;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result drive_value %0d", $time, drive);
                errors++;
            end else begin
                r = pending_q.pop_front();
                if (drive !== r.drive) begin
                    $display("%0t drive_value expected %0d actual %0d", $time, r.drive, drive);
                    errors++;
                end
                if (integ !== r.integ) begin
                    $display("%0t integral_applied expected %0b actual %0b",
                             $time, r.integ, integ);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_addr;
    logic [22:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [23:0] i_target_speed;
    logic signed [23:0] i_measured_speed;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_drive_value;
    logic               o_integral_applied;

    t_pid_scoreboard sb = new();
    bit req_gaps;
    bit res_gaps;
    int drift_err;
    int idle_cycles;

    fuzzy_incremental_pid_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_target_speed     (i_target_speed),
        .i_measured_speed   (i_measured_speed),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_drive_value      (o_drive_value),
        .o_integral_applied (o_integral_applied)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_request(logic signed [23:0] target, logic signed [23:0] meas);
        int gap;
        gap = req_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_target_speed <= target;
        i_measured_speed <= meas;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(target, meas);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [22:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(addr, data);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_phase(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                             logic [22:0] mg, logic [22:0] so);
        settle();
        write_reg(CFG_GAIN_P, {7'($urandom), gp});
        write_reg(CFG_GAIN_I, {7'($urandom), gi});
        write_reg(CFG_GAIN_D, {7'($urandom), gd});
        write_reg(CFG_MARGIN, mg);
        write_reg(CFG_SEP_OFFS, so);
        write_reg(3'($urandom_range(NUM_REGS, 7)), 23'($urandom));
        i_cfg_we <= 1'b0;
        req_gaps = $urandom_range(0, 3) != 0;
        res_gaps = $urandom_range(0, 3) != 0;
    endtask

    task automatic send_random();
        int mode;
        int t;
        int e;
        logic signed [23:0] ext [4];
        ext = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF};
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            if ($urandom_range(0, 7) == 0) begin
                drift_err = int'($urandom_range(0, 1536)) - 768;
            end else begin
                drift_err += int'($urandom_range(0, 1600)) - 800;
            end
            if (drift_err > 1000) drift_err = 1000;
            if (drift_err < -1000) drift_err = -1000;
            t = int'($urandom_range(0, 8388608)) - 4194304;
            send_request(24'(t), 24'(t - drift_err));
        end else if (mode == 6) begin
            send_request(24'($urandom), 24'($urandom));
        end else if (mode == 7) begin
            send_request(ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)]);
        end else begin
            e = int'($urandom_range(0, 6000)) - 3000;
            t = int'($urandom_range(0, 16000)) - 8000;
            send_request(24'(t), 24'(t - e));
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_target_speed <= '0;
        i_measured_speed <= '0;
        i_stall <= 1'b0;
        req_gaps = 1'b1;
        res_gaps = 1'b1;
        drift_err = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: only the fuzzy gain offsets act here.
        send_request(24'sd0, 24'sd0);
        send_request(24'sd768, 24'sd0);
        send_request(24'sd768, 24'sd0);
        send_request(-24'sd768, 24'sd0);
        send_request(24'sd769, 24'sd0);
        send_request(24'sd0, 24'sd769);
        send_request(24'sd0, 24'sd1);
        send_request(24'sd300, -24'sd200);
        send_request(24'sd5120, 24'sd5000);
        send_request(24'sd5000, 24'sd7000);
        send_request(24'sd5000, 24'sd3000);
        send_request(24'sh7FFFFF, 24'sh800000);
        send_request(24'sh800000, 24'sh7FFFFF);
        send_request(24'sh7FFFFF, 24'sh7FFFFF);
        send_request(24'sh800000, 24'sh800000);
        send_request(-24'sd1, 24'sd0);

        set_phase(16'd256, 16'd64, 16'd32, 23'd1280, 23'd5120);
        send_request(24'sd100, 24'sd50);
        send_request(24'sd100, 24'sd2000);
        send_request(24'sd100, -24'sd2000);
        send_request(24'sd6000, 24'sd5900);
        repeat (ITEMS_PER_PHASE) send_random();

        set_phase(16'h8000, 16'h7FFF, 16'h8000, 23'd0, 23'd0);
        repeat (ITEMS_PER_PHASE) send_random();

        set_phase(16'h7FFF, 16'h8000, 16'h7FFF, 23'h7FFFFF, 23'h7FFFFF);
        repeat (ITEMS_PER_PHASE) send_random();

        set_phase(16'($urandom), 16'($urandom), 16'($urandom), 23'($urandom), 23'($urandom));
        repeat (ITEMS_PER_PHASE) send_random();

        set_phase(16'(int'($urandom_range(0, 1024)) - 512),
                  16'(int'($urandom_range(0, 1024)) - 512),
                  16'(int'($urandom_range(0, 1024)) - 512),
                  23'($urandom_range(0, 4000)), 23'($urandom_range(0, 12000)));
        repeat (ITEMS_PER_PHASE) send_random();

        settle();
        if (sb.errors == 0) begin
            $display("fuzzy_incremental_pid_unit regression: pass");
        end else begin
            $display("fuzzy_incremental_pid_unit regression: fail");
        end
        $finish;
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = res_gaps ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            sb.check_result(o_drive_value, o_integral_applied);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("fuzzy_incremental_pid_unit regression: fail");
                $finish;
            end
        end
    end

endmodule
